### sv/wsfd_pkg.sv
// Shared types and constants for the websocket frame decoder.
`default_nettype none

package wsfd_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_W      = 64;
   localparam int CNT_W      = 63;

   localparam logic [62:0] MAX_PAYLOAD_RESET = 63'd65536;
   localparam logic [63:0] CTRL_MAX_LEN      = 64'd125;
   localparam logic [6:0]  LEN_CODE_16       = 7'd126;
   localparam logic [6:0]  LEN_CODE_64       = 7'd127;

   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_HDR_SHORT    = 4'd1;
   localparam logic [3:0] ST_RSV          = 4'd2;
   localparam logic [3:0] ST_OPCODE       = 4'd3;
   localparam logic [3:0] ST_UNMASKED     = 4'd4;
   localparam logic [3:0] ST_EXT_SHORT    = 4'd5;
   localparam logic [3:0] ST_NONCANONICAL = 4'd6;
   localparam logic [3:0] ST_LIMIT        = 4'd7;
   localparam logic [3:0] ST_KEY_SHORT    = 4'd8;
   localparam logic [3:0] ST_SIZE         = 4'd9;
   localparam logic [3:0] ST_CONTROL      = 4'd10;
   localparam logic [3:0] ST_LAST_CODE    = ST_CONTROL;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        byte_valid;
      logic        frame_done;
      logic [3:0]  status;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [62:0] payload_length;
   } rsp_payload_type;

endpackage

`default_nettype wire

### sv/websocket_frame_decoder.sv
// Websocket frame decoder: header parse, payload unmask and frame status.
// A result is in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; req_ready drops only while a result waits with rsp_ready low.
// Header bytes that are not last produce no result.
// Reset (synchronous) returns the parser to the first header byte and the
// registers to require_mask 0, max_payload 65536.
`default_nettype none

module websocket_frame_decoder
   import wsfd_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire req_payload_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output rsp_payload_type       rsp_data,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire [CSR_ADDR_W-1:0]  paddr,
   input  wire [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXT16   = 3'd2;
   localparam logic [2:0] PH_EXT64   = 3'd3;
   localparam logic [2:0] PH_KEY     = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_DRAIN   = 3'd6;

   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [31:0]      key_ff, key_in;
   logic             fin_ff, fin_in;
   logic [3:0]       op_ff, op_in;
   logic             mask_ff, mask_in;
   logic [3:0]       err_ff, err_in;
   logic             req_mask_ff;
   logic [62:0]      max_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_payload_type  out_ff, result;

   logic       fire, emit, len_done, pvalid, op_known, is_ctrl, csr_wr;
   logic [7:0] b, pbyte, kbyte;
   logic [3:0] status;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign prdata    = paddr[3] ? {1'b0, max_ff} : {{(CSR_DATA_W-1){1'b0}}, req_mask_ff};
   assign req_ready = !out_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign b         = req_data.data_byte;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      case (b[3:0]) inside
         OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: op_known = 1'b1;
         default: op_known = 1'b0;
      endcase
   end

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: kbyte = key_ff[31:24];
         2'd1: kbyte = key_ff[23:16];
         2'd2: kbyte = key_ff[15:8];
         default: kbyte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      fin_in   = fin_ff;
      op_in    = op_ff;
      mask_in  = mask_ff;
      err_in   = err_ff;
      len_done = 1'b0;
      pvalid   = 1'b0;
      pbyte    = 8'd0;
      unique case (phase_ff)
         PH_HDR0: begin
            fin_in = b[7];
            op_in  = b[3:0];
            if (b[6:4] != 3'd0) begin
               err_in = ST_RSV;
            end else if (!op_known) begin
               err_in = ST_OPCODE;
            end
            phase_in = PH_HDR1;
         end
         PH_HDR1: begin
            if (err_ff != ST_OK) begin
               phase_in = PH_DRAIN;
            end else begin
               mask_in = b[7];
               if (req_mask_ff && !b[7]) begin
                  err_in   = ST_UNMASKED;
                  phase_in = PH_DRAIN;
               end else begin
                  cnt_in = '0;
                  len_in = '0;
                  if (b[6:0] == LEN_CODE_16) begin
                     phase_in = PH_EXT16;
                  end else if (b[6:0] == LEN_CODE_64) begin
                     phase_in = PH_EXT64;
                  end else begin
                     len_in   = {{(LEN_W-7){1'b0}}, b[6:0]};
                     len_done = 1'b1;
                  end
               end
            end
         end
         PH_EXT16, PH_EXT64: begin
            len_in = {len_ff[LEN_W-9:0], b};
            cnt_in = cnt_ff + 63'd1;
            if (phase_ff == PH_EXT16 && cnt_in == 63'd2) begin
               len_done = 1'b1;
            end else if (phase_ff == PH_EXT64 && cnt_in == 63'd8) begin
               if (len_in[LEN_W-1]) begin
                  err_in   = ST_NONCANONICAL;
                  phase_in = PH_DRAIN;
               end else begin
                  len_done = 1'b1;
               end
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], b};
            cnt_in = cnt_ff + 63'd1;
            if (cnt_in == 63'd4) begin
               cnt_in   = '0;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if ({1'b0, cnt_ff} < len_ff) begin
               pvalid = 1'b1;
               pbyte  = mask_ff ? (b ^ kbyte) : b;
               cnt_in = cnt_ff + 63'd1;
            end else begin
               err_in   = ST_SIZE;
               phase_in = PH_DRAIN;
            end
         end
         default: begin
            phase_in = PH_DRAIN;
         end
      endcase
      if (len_done) begin
         if (len_in > {1'b0, max_ff}) begin
            err_in   = ST_LIMIT;
            phase_in = PH_DRAIN;
         end else begin
            cnt_in   = '0;
            phase_in = mask_in ? PH_KEY : PH_PAYLOAD;
         end
      end
   end

   assign is_ctrl = (op_in == OP_CLOSE) || (op_in == OP_PING) || (op_in == OP_PONG);

   always_comb begin
      status = ST_OK;
      if (req_data.last_byte) begin
         if (phase_in == PH_HDR1) begin
            status = ST_HDR_SHORT;
         end else if (phase_in == PH_DRAIN) begin
            status = err_in;
         end else if (phase_in == PH_EXT16 || phase_in == PH_EXT64) begin
            status = ST_EXT_SHORT;
         end else if (phase_in == PH_KEY) begin
            status = ST_KEY_SHORT;
         end else if ({1'b0, cnt_in} != len_in) begin
            status = ST_SIZE;
         end else if (is_ctrl && (!fin_in || len_in > CTRL_MAX_LEN)) begin
            status = ST_CONTROL;
         end
      end
   end

   always_comb begin
      result.payload_byte   = pbyte;
      result.byte_valid     = pvalid;
      result.frame_done     = req_data.last_byte;
      result.status         = status;
      result.fin            = fin_in;
      result.opcode         = op_in;
      result.masked         = mask_in;
      result.payload_length = len_in[62:0];
   end

   assign emit         = pvalid || req_data.last_byte;
   assign out_valid_in = (out_valid_ff && !rsp_ready) || (fire && emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         cnt_ff       <= '0;
         len_ff       <= '0;
         key_ff       <= '0;
         fin_ff       <= 1'b0;
         op_ff        <= 4'd0;
         mask_ff      <= 1'b0;
         err_ff       <= ST_OK;
         req_mask_ff  <= 1'b0;
         max_ff       <= MAX_PAYLOAD_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_wr) begin
            if (paddr[3]) begin
               max_ff <= pwdata[62:0];
            end else begin
               req_mask_ff <= pwdata[0];
            end
         end
         if (fire) begin
            if (req_data.last_byte) begin
               phase_ff <= PH_HDR0;
               cnt_ff   <= '0;
               len_ff   <= '0;
               key_ff   <= '0;
               fin_ff   <= 1'b0;
               op_ff    <= 4'd0;
               mask_ff  <= 1'b0;
               err_ff   <= ST_OK;
            end else begin
               phase_ff <= phase_in;
               cnt_ff   <= cnt_in;
               len_ff   <= len_in;
               key_ff   <= key_in;
               fin_ff   <= fin_in;
               op_ff    <= op_in;
               mask_ff  <= mask_in;
               err_ff   <= err_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_ff <= result;
      end
   end

endmodule

`default_nettype wire

### sv/wsfd_checker.sv
// Port-level assertions for the websocket frame decoder, with its bind.
`default_nettype none

module wsfd_checker
   import wsfd_pkg::*;
(
   input wire                  clock,
   input wire                  reset,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire rsp_payload_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_done |-> rsp_data.status == ST_OK)
      else $error("status set on an item without frame_done");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_LAST_CODE)
      else $error("status code out of range");

   a_byte_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.payload_byte == 8'd0)
      else $error("payload_byte nonzero without byte_valid");

   a_byte_needs_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_valid |-> rsp_data.payload_length != 63'd0)
      else $error("payload byte emitted for a zero-length frame");

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### dv/websocket_frame_decoder_tb.sv
// Self-checking testbench for the websocket frame decoder: header, length, mask and status paths.
module websocket_frame_decoder_tb
   import wsfd_pkg::*;
();

   localparam logic [CSR_ADDR_W-1:0] ADDR_REQUIRE_MASK = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_PAYLOAD  = 4'h8;
   localparam logic [3:0]            OP_RESERVED       = 4'hB;
   localparam int                    ITEM_TARGET       = 850;
   localparam int                    HOLD_CYCLES       = 300;
   localparam int                    STALL_LIMIT       = 2000;
   localparam int                    DRAIN_CYCLES      = 4;

   typedef enum logic [2:0] {
      AT_HDR0, AT_HDR1, AT_LEN16, AT_LEN64, AT_KEY, AT_PAYLOAD, AT_DRAIN
   } parse_phase_type;

   typedef enum logic [1:0] {FORM_7, FORM_16, FORM_64} len_form_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   websocket_frame_decoder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // decoder model state
   logic                  cfg_require_mask;
   logic [62:0]           cfg_max_payload;
   parse_phase_type       m_phase;
   logic [63:0]           m_count;
   logic [63:0]           m_length;
   logic [31:0]           m_key;
   logic                  m_fin;
   logic [3:0]            m_opcode;
   logic                  m_masked;
   logic [3:0]            m_error;

   rsp_payload_type       pending_results[$];
   logic [7:0]            frame_bytes[$];
   int                    error_count = 0;
   int                    items_sent = 0;
   int                    frames_sent = 0;
   int                    results_checked = 0;
   logic [10:0]           status_seen = '0;
   bit                    calm = 1'b0;
   int                    hold_requested = 0;
   int                    hold_served = 0;
   int                    hold_left = 0;
   int                    quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic clear_frame();
      m_phase = AT_HDR0;
      m_count = '0;
      m_length = '0;
      m_key = '0;
      m_fin = 1'b0;
      m_opcode = '0;
      m_masked = 1'b0;
      m_error = ST_OK;
   endtask

   task automatic fail_frame(input logic [3:0] code);
      m_error = code;
      m_phase = AT_DRAIN;
   endtask

   task automatic finish_length();
      if (m_length > {1'b0, cfg_max_payload}) begin
         fail_frame(ST_LIMIT);
      end else begin
         m_count = '0;
         m_phase = m_masked ? AT_KEY : AT_PAYLOAD;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last,
                              output bit has_result, output rsp_payload_type res);
      logic       emit;
      logic [7:0] pbyte;
      logic [3:0] status;
      emit = 1'b0;
      pbyte = '0;
      status = ST_OK;
      case (m_phase)
         AT_HDR0: begin
            m_fin = b[7];
            m_opcode = b[3:0];
            if (b[6:4] != 3'b000) begin
               m_error = ST_RSV;
            end else if (!(m_opcode == OP_CONT || m_opcode == OP_TEXT || m_opcode == OP_BIN ||
                           m_opcode == OP_CLOSE || m_opcode == OP_PING ||
                           m_opcode == OP_PONG)) begin
               m_error = ST_OPCODE;
            end
            m_phase = AT_HDR1;
         end
         AT_HDR1: begin
            if (m_error != ST_OK) begin
               m_phase = AT_DRAIN;
            end else begin
               m_masked = b[7];
               if (cfg_require_mask && !m_masked) begin
                  fail_frame(ST_UNMASKED);
               end else begin
                  m_count = '0;
                  m_length = '0;
                  if (b[6:0] == LEN_CODE_16) begin
                     m_phase = AT_LEN16;
                  end else if (b[6:0] == LEN_CODE_64) begin
                     m_phase = AT_LEN64;
                  end else begin
                     m_length = {57'd0, b[6:0]};
                     finish_length();
                  end
               end
            end
         end
         AT_LEN16, AT_LEN64: begin
            m_length = {m_length[55:0], b};
            m_count = m_count + 1;
            if (m_phase == AT_LEN16 && m_count == 2) begin
               finish_length();
            end else if (m_phase == AT_LEN64 && m_count == 8) begin
               if (m_length[63]) fail_frame(ST_NONCANONICAL);
               else finish_length();
            end
         end
         AT_KEY: begin
            m_key = {m_key[23:0], b};
            m_count = m_count + 1;
            if (m_count == 4) begin
               m_count = '0;
               m_phase = AT_PAYLOAD;
            end
         end
         AT_PAYLOAD: begin
            if (m_count < m_length) begin
               // key bytes apply most significant first
               pbyte = m_masked ? (b ^ m_key[8*(3 - m_count[1:0]) +: 8]) : b;
               emit = 1'b1;
               m_count = m_count + 1;
            end else begin
               fail_frame(ST_SIZE);
            end
         end
         default: m_phase = AT_DRAIN;
      endcase

      if (last) begin
         if (m_phase == AT_HDR1) status = ST_HDR_SHORT;
         else if (m_phase == AT_DRAIN) status = m_error;
         else if (m_phase == AT_LEN16 || m_phase == AT_LEN64) status = ST_EXT_SHORT;
         else if (m_phase == AT_KEY) status = ST_KEY_SHORT;
         else if (m_count != m_length) status = ST_SIZE;
         else if ((m_opcode == OP_CLOSE || m_opcode == OP_PING || m_opcode == OP_PONG) &&
                  (!m_fin || m_length > CTRL_MAX_LEN)) status = ST_CONTROL;
         else status = ST_OK;
      end

      has_result = emit || last;
      res.payload_byte = pbyte;
      res.byte_valid = emit;
      res.frame_done = last;
      res.status = status;
      res.fin = m_fin;
      res.opcode = m_opcode;
      res.masked = m_masked;
      res.payload_length = m_length[62:0];
      if (last) clear_frame();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last);
      req_payload_type item;
      bit              has_result;
      rsp_payload_type res;
      if (!calm) begin
         while ($urandom_range(99) < 27) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      item.data_byte = value;
      item.last_byte = last;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      decode_byte(value, last, has_result, res);
      if (has_result) begin
         pending_results = {pending_results, res};
         if (last) status_seen[res.status] = 1'b1;
      end
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_REQUIRE_MASK) cfg_require_mask = data[0];
      else cfg_max_payload = data[62:0];
      @(posedge clock);
   endtask

   task automatic set_limits(input logic require_mask, input logic [62:0] limit);
      wait_for_drain();
      csr_write(ADDR_REQUIRE_MASK, {63'd0, require_mask});
      csr_write(ADDR_MAX_PAYLOAD, {1'b0, limit});
   endtask

   task automatic build_frame(input logic [7:0] head, input logic mask, input len_form_type form,
                              input logic [63:0] len_value, input int n_payload);
      frame_bytes.delete();
      frame_bytes = {frame_bytes, head};
      case (form)
         FORM_7: frame_bytes = {frame_bytes, {mask, len_value[6:0]}};
         FORM_16: begin
            frame_bytes = {frame_bytes, {mask, LEN_CODE_16}};
            frame_bytes = {frame_bytes, len_value[15:8]};
            frame_bytes = {frame_bytes, len_value[7:0]};
         end
         default: begin
            frame_bytes = {frame_bytes, {mask, LEN_CODE_64}};
            for (int i = 7; i >= 0; i--) frame_bytes = {frame_bytes, len_value[8*i +: 8]};
         end
      endcase
      if (mask) repeat (4) frame_bytes = {frame_bytes, 8'($urandom_range(255))};
      repeat (n_payload) frame_bytes = {frame_bytes, 8'($urandom_range(255))};
   endtask

   task automatic send_buffer(input int n);
      for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
      frames_sent++;
   endtask

   task automatic send_random_frame();
      int           kind;
      int           n_pay;
      logic [3:0]   op;
      logic         mask;
      logic         fin;
      logic [63:0]  len;
      len_form_type form;
      kind = $urandom_range(99);
      case ($urandom_range(5))
         0: op = OP_CONT;
         1: op = OP_TEXT;
         2: op = OP_BIN;
         3: op = OP_CLOSE;
         4: op = OP_PING;
         default: op = OP_PONG;
      endcase
      fin = ($urandom_range(99) < 80);
      mask = cfg_require_mask ? ($urandom_range(99) < 95) : 1'($urandom_range(1));
      len = ($urandom_range(99) < 5) ? 64'($urandom_range(126, 300))
                                     : 64'($urandom_range(0, 24));
      if (cfg_max_payload < 300 && $urandom_range(9) == 0)
         len = {1'b0, cfg_max_payload} + 64'($urandom_range(1));
      if (len > 125) form = $urandom_range(1) ? FORM_16 : FORM_64;
      else if ($urandom_range(99) < 60) form = FORM_7;
      else form = $urandom_range(1) ? FORM_16 : FORM_64;
      n_pay = int'(len);
      if (kind < 60) begin
         build_frame({fin, 3'b000, op}, mask, form, len, n_pay);
         send_buffer(frame_bytes.size());
      end else if (kind < 75) begin
         // buffer cut short somewhere
         build_frame({fin, 3'b000, op}, mask, form, len, n_pay);
         send_buffer(int'($urandom_range(1, frame_bytes.size() - 1)));
      end else if (kind < 85) begin
         build_frame({fin, 3'b000, op}, mask, form, len, n_pay + int'($urandom_range(1, 3)));
         send_buffer(frame_bytes.size());
      end else if (kind < 92) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 8)) frame_bytes = {frame_bytes, 8'($urandom_range(255))};
         send_buffer(frame_bytes.size());
      end else begin
         build_frame({fin, 3'b000, op}, mask, FORM_64, {$urandom, $urandom},
                     int'($urandom_range(0, 4)));
         send_buffer(frame_bytes.size());
      end
   endtask

   task automatic test_header_errors();
      send_byte(8'hFF, 1'b1);
      send_byte({1'b1, 3'b100, OP_TEXT}, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte({1'b1, 3'b000, OP_RESERVED}, 1'b0);
      send_byte(8'h80, 1'b1);
      build_frame({1'b1, 3'b000, OP_BIN}, 1'b0, FORM_16, 64'h0100, 0);
      send_buffer(3);
      build_frame({1'b1, 3'b000, OP_BIN}, 1'b1, FORM_7, 64'd1, 1);
      send_buffer(3);
      build_frame({1'b1, 3'b000, OP_BIN}, 1'b0, FORM_7, 64'd0, 1);
      send_buffer(frame_bytes.size());
      build_frame({1'b0, 3'b000, OP_PING}, 1'b0, FORM_7, 64'd0, 0);
      send_buffer(frame_bytes.size());
      build_frame({1'b1, 3'b000, OP_CLOSE}, 1'b1, FORM_7, 64'd1, 1);
      send_buffer(frame_bytes.size());
   endtask

   task automatic test_register_settings();
      set_limits(1'b1, '0);
      build_frame({1'b1, 3'b000, OP_TEXT}, 1'b1, FORM_7, 64'd1, 1);
      send_buffer(frame_bytes.size());
      build_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, FORM_7, 64'd0, 0);
      send_buffer(frame_bytes.size());
      repeat (6) send_random_frame();
      set_limits(1'b0, '1);
      build_frame({1'b1, 3'b000, OP_BIN}, 1'b1, FORM_64, 64'h8000_0000_0000_0000, 0);
      send_buffer(frame_bytes.size());
      build_frame({1'b1, 3'b000, OP_PONG}, 1'b1, FORM_16, 64'd126, 126);
      send_buffer(frame_bytes.size());
      build_frame({1'b1, 3'b000, OP_BIN}, 1'b0, FORM_64, 64'h7FFF_FFFF_FFFF_FFFF, 2);
      send_buffer(frame_bytes.size());
      repeat (6) send_random_frame();
      set_limits(1'b0, 63'd125);
      repeat (8) send_random_frame();
      set_limits(1'b0, 63'd20);
      repeat (8) send_random_frame();
      set_limits(1'b1, MAX_PAYLOAD_RESET);
      repeat (8) send_random_frame();
   endtask

   task automatic test_back_to_back();
      wait_for_drain();
      calm = 1'b1;
      repeat (10) send_random_frame();
      wait_for_drain();
      calm = 1'b0;
   endtask

   task automatic test_output_stall();
      set_limits(1'b0, MAX_PAYLOAD_RESET);
      build_frame({1'b1, 3'b000, OP_BIN}, 1'b0, FORM_7, 64'd80, 80);
      hold_requested++;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         if (i == 60) wait_for_drain();
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      frames_sent++;
   endtask

   task automatic test_random_frames();
      int n_frames;
      logic [62:0] limit;
      n_frames = 0;
      while (items_sent < ITEM_TARGET) begin
         if (n_frames % 12 == 0) begin
            case ($urandom_range(3))
               0: limit = 63'($urandom_range(0, 40));
               1: limit = MAX_PAYLOAD_RESET;
               2: limit = 63'({$urandom, $urandom});
               default: limit = '1;
            endcase
            set_limits(1'($urandom_range(1)), limit);
         end
         send_random_frame();
         n_frames++;
      end
   endtask

   // receiver: random stalls, quiet stretches and long hold-offs
   always @(posedge clock) begin
      if (hold_served != hold_requested) begin
         hold_served = hold_requested;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 27);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", 64'(rsp_data.payload_length), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", 64'(rsp_data.payload_byte),
                               64'(want.payload_byte));
            if (rsp_data.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", 64'(rsp_data.byte_valid), 64'(want.byte_valid));
            if (rsp_data.frame_done !== want.frame_done)
               report_mismatch("frame_done", 64'(rsp_data.frame_done), 64'(want.frame_done));
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.fin !== want.fin)
               report_mismatch("fin", 64'(rsp_data.fin), 64'(want.fin));
            if (rsp_data.opcode !== want.opcode)
               report_mismatch("opcode", 64'(rsp_data.opcode), 64'(want.opcode));
            if (rsp_data.masked !== want.masked)
               report_mismatch("masked", 64'(rsp_data.masked), 64'(want.masked));
            if (rsp_data.payload_length !== want.payload_length)
               report_mismatch("payload_length", 64'(rsp_data.payload_length),
                               64'(want.payload_length));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("websocket_frame_decoder_tb failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      cfg_require_mask = 1'b0;
      cfg_max_payload = MAX_PAYLOAD_RESET;
      clear_frame();
      test_header_errors();
      test_register_settings();
      test_back_to_back();
      test_output_stall();
      test_random_frames();
      wait_for_drain();
      $display("covered %0d frames, %0d bytes, %0d results checked, %0d mismatches",
               frames_sent, items_sent, results_checked, error_count);
      $display("frame status codes seen, one bit per code from 10 down to 0: %b", status_seen);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("websocket_frame_decoder_tb passed");
      end else begin
         $display("websocket_frame_decoder_tb failed");
      end
      $finish;
   end

endmodule

### files.f
sv/wsfd_pkg.sv
sv/websocket_frame_decoder.sv
sv/wsfd_checker.sv
dv/websocket_frame_decoder_tb.sv
